/* design/pie_pkg.sv */
// Shared types, character codes and error codes for the postfix integer evaluator.
package pie_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic        [1:0]        error_code;
  } out_item_t;

endpackage

/* design/postfix_integer_evaluator.sv */
// Postfix evaluator: a character is registered in S_IDLE and executed in S_EXEC.
// A new character is taken only back in S_IDLE; a divide holds the input for the
// bit-serial divider in S_DIV. The stack lives in a RAM with one read port,
// the top entry in a register. A final result waits in the output register.
// Synchronous reset empties the stack and clears the error; RAM is not cleared.
module postfix_integer_evaluator #(
  parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pie_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pie_pkg::out_item_t out_data
);

  localparam int W  = pie_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [W-1:0]  tos, tos_next;
  pie_pkg::err_t err, err_next;
  logic [7:0]    char_q;
  logic          last_q;

  logic          in_xfer;
  logic          is_digit, is_op, op_div;
  logic          have_two, need_div, finish, commit;
  logic [W-1:0]  b_val, res;
  logic          div_busy;
  logic signed [W-1:0] div_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // second entry sits in RAM just below the cached top
  assign ram_raddr = AW'(count - CW'(2));

  pie_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos),
    .re    (in_xfer),
    .raddr (ram_raddr),
    .rdata (b_val)
  );

  assign is_digit = (char_q >= pie_pkg::CH_ZERO) && (char_q <= pie_pkg::CH_NINE);
  assign op_div   = (char_q == pie_pkg::CH_SLASH);
  assign is_op    = (char_q == pie_pkg::CH_PLUS) || (char_q == pie_pkg::CH_MINUS) ||
                    (char_q == pie_pkg::CH_STAR) || op_div;
  assign have_two = (count >= CW'(2));
  assign need_div = op_div && have_two && (tos != '0);

  pie_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EXEC && need_div),
    .num   ($signed(b_val)),
    .den   ($signed(tos)),
    .busy  (div_busy),
    .quo   (div_q)
  );

  assign finish = (state == S_EXEC && !need_div) || (state == S_DIV && !div_busy);
  // hold a final character until the output register is free
  assign commit = finish && (!last_q || !out_valid || out_ready);

  always_comb begin
    unique case (char_q)
      pie_pkg::CH_PLUS:  res = b_val + tos;
      pie_pkg::CH_MINUS: res = b_val - tos;
      pie_pkg::CH_STAR:  res = b_val * tos;
      default:           res = (tos == '0) ? '0 : W'(div_q);
    endcase
  end

  always_comb begin
    count_next = count;
    tos_next   = tos;
    err_next   = err;
    ram_we     = 1'b0;
    ram_waddr  = AW'(count - CW'(1));
    if (is_digit) begin
      if (count >= CW'(STACK_DEPTH)) begin
        if (err == pie_pkg::ERR_NONE) err_next = pie_pkg::ERR_OVER;
      end else begin
        ram_we     = commit && (count != '0);
        tos_next   = W'(char_q - pie_pkg::CH_ZERO);
        count_next = count + CW'(1);
      end
    end else if (is_op) begin
      if (!have_two) begin
        if (err == pie_pkg::ERR_NONE) err_next = pie_pkg::ERR_UNDER;
      end else begin
        if (op_div && tos == '0 && err == pie_pkg::ERR_NONE) err_next = pie_pkg::ERR_DIVZ;
        tos_next   = res;
        count_next = count - CW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (need_div) state_next = S_DIV;
        else if (commit) state_next = S_IDLE;
      end
      S_DIV:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= pie_pkg::ERR_NONE;
    end else begin
      state <= state_next;
      if (commit) begin
        count <= last_q ? '0 : count_next;
        err   <= last_q ? pie_pkg::ERR_NONE : err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_q <= in_data.char_code;
      last_q <= in_data.last_char;
    end
    if (commit) begin
      tos <= tos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && last_q) begin
      out_data.value      <= (count_next == '0) ? '0 : $signed(tos_next);
      out_data.error_code <= (count_next == '0 && err_next == pie_pkg::ERR_NONE) ?
                             pie_pkg::ERR_UNDER : err_next;
    end
  end

endmodule

/* design/pie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pie_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pie_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [pie_pkg::DATA_W-1:0] num,
  input  logic signed [pie_pkg::DATA_W-1:0] den,
  output logic                             busy,
  output logic signed [pie_pkg::DATA_W-1:0] quo
);

  localparam int W  = pie_pkg::DATA_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  rem;
  logic [W-1:0]  q_mag;
  logic [W-1:0]  d_mag;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem, q_mag[W-1]};
  assign diff    = shifted - {1'b0, d_mag};
  assign quo     = neg ? -$signed(q_mag) : $signed(q_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      q_mag <= num[W-1] ? -num : num;
      d_mag <= den[W-1] ? -den : den;
      neg   <= num[W-1] ^ den[W-1];
      cnt   <= CW'(W - 1);
    end else if (busy) begin
      // keep the trial subtraction only when it does not go negative
      rem   <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
      q_mag <= {q_mag[W-2:0], ~diff[W]};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

/* design/pie_checker.sv */
// Port-level checker for the postfix evaluator, bound to the top level.
module pie_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input pie_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pie_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a waiting character keeps its payload until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // in_ready drops after every transfer in
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // no result can appear in the cycle right after a transfer in
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind postfix_integer_evaluator pie_checker u_pie_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
